FILE: sv/max_heap_priority_queue_defines.svh
// Assertion macros shared by the heap priority queue RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF

// property holds at every clock edge outside reset
`define MHPQ_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("mhpq: invariant check failed");

// same-cycle implication
`define MHPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mhpq: implication check failed");

// next-cycle implication
`define MHPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mhpq: next-cycle check failed");

`else

`define MHPQ_ASSERT(lbl, clk, rst_n, cond)
`define MHPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MHPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/mhpq_pkg.sv
// Shared types and constants for the max-heap priority queue.
// No dependencies; used by mhpq_cmp and max_heap_priority_queue.
package mhpq_pkg;

    localparam int DATA_W    = 32;
    localparam int CAP_DEF   = 16;
    localparam int CNT_OUT_W = 5;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 72;

    // command carried in the input tuser bit
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_DELETE = 1'b1
    } t_cmd;

    // which operand the compare unit found largest
    typedef enum logic [1:0] {
        PICK_CUR,
        PICK_B,
        PICK_C
    } t_pick;

    typedef struct packed {
        t_pick                    pick;
        logic signed [DATA_W-1:0] max_val;
    } t_cmp_res;

endpackage

FILE: sv/mhpq_cmp.sv
// Shared three-way signed compare unit for sift-up and sift-down.
// Depends on mhpq_pkg.
module mhpq_cmp
    import mhpq_pkg::*;
(
    input  logic signed [DATA_W-1:0] i_cur,
    input  logic signed [DATA_W-1:0] i_b,
    input  logic                     i_b_ok,
    input  logic signed [DATA_W-1:0] i_c,
    input  logic                     i_c_ok,
    output t_cmp_res                 o_res
);

    // strict compares: on ties the current entry wins
    always_comb begin
        t_cmp_res res;
        res.pick    = PICK_CUR;
        res.max_val = i_cur;
        if (i_b_ok && (i_b > res.max_val)) begin
            res.pick    = PICK_B;
            res.max_val = i_b;
        end
        if (i_c_ok && (i_c > res.max_val)) begin
            res.pick    = PICK_C;
            res.max_val = i_c;
        end
        o_res = res;
    end

endmodule

FILE: sv/max_heap_priority_queue.sv
// Bounded binary max-heap priority queue: sequencer, heap memory, result register.
// Depends on mhpq_pkg, mhpq_cmp and max_heap_priority_queue_defines.svh.
//
// Usage:
//   Input channel (i_s_*): one beat per operation. tuser[0] is the command
//   (0 insert, 1 delete-max), tdata is the signed 32-bit value to insert.
//   Output channel (o_m_*): exactly one result beat per input beat, in order.
//   The heap is walked one tree level at a time through one shared compare
//   unit and a memory with registered reads: each level passes a read state
//   and a compare state. Rejected operations go straight to the result
//   state. o_s_tready is high only while no operation is in work.
//   A finished result sits in the output register; the next operation is
//   taken while it waits, and the sequencer holds its next result until the
//   receiver takes the previous one.
//   Reset empties the queue (count zero); heap memory is not cleared, since
//   only entries below the count are ever read.
`include "max_heap_priority_queue_defines.svh"

module max_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = CAP_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input beats
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [31:0] value
    input  logic [0:0]             i_s_tuser,   // [0] command
    // result beats
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // [31:0] removed_value, [32] removed_valid, [64:33] top_value,
    // [69:65] entry_count, [70] overflow, [71] underflow
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_UP_FIN,
        S_DEL_RD,
        S_DEL_LD,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic [CW-1:0]            r_count;
    logic [AW-1:0]            r_pos;
    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] r_top;
    logic signed [DATA_W-1:0] r_removed;
    logic                     r_rvalid;
    logic                     r_ovf;
    logic                     r_unf;
    logic                     r_out_valid;
    logic [OUT_TDATA_W-1:0]   r_out_data;

    logic signed [DATA_W-1:0] r_mem [CAPACITY];
    logic signed [DATA_W-1:0] r_rd0;
    logic signed [DATA_W-1:0] r_rd1;

    logic                     s_accept;
    t_cmd                     cmd;
    logic [IW-1:0]            idx_l;
    logic [IW-1:0]            idx_r;
    logic [IW-1:0]            count_ext;
    logic [AW-1:0]            parent;
    logic                     l_ok;
    logic                     r_ok;
    logic [AW-1:0]            raddr0;
    logic [AW-1:0]            raddr1;
    logic                     we;
    logic [AW-1:0]            waddr;
    logic signed [DATA_W-1:0] wdata;
    logic signed [DATA_W-1:0] cmp_cur;
    logic signed [DATA_W-1:0] cmp_b;
    logic                     cmp_b_ok;
    logic                     cmp_c_ok;
    t_cmp_res                 cmp_res;
    logic                     out_load;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign cmd        = t_cmd'(i_s_tuser[0]);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // tree index arithmetic
    assign idx_l     = IW'({r_pos, 1'b1});
    assign idx_r     = idx_l + IW'(1);
    assign count_ext = IW'(r_count);
    assign parent    = AW'((r_pos - AW'(1)) >> 1);
    assign l_ok      = (idx_l < count_ext);
    assign r_ok      = (idx_r < count_ext);

    // memory read addresses
    always_comb begin
        case (r_state)
            S_UP_RD:  raddr0 = parent;
            S_DEL_RD: raddr0 = r_count[AW-1:0];
            default:  raddr0 = idx_l[AW-1:0];
        endcase
        raddr1 = idx_r[AW-1:0];
    end

    // compare unit operand select
    always_comb begin
        if (r_state == S_UP_CMP) begin
            cmp_cur  = r_rd0;
            cmp_b    = r_val;
            cmp_b_ok = 1'b1;
            cmp_c_ok = 1'b0;
        end else begin
            cmp_cur  = r_val;
            cmp_b    = r_rd0;
            cmp_b_ok = l_ok;
            cmp_c_ok = r_ok;
        end
    end

    mhpq_cmp u_cmp (
        .i_cur  (cmp_cur),
        .i_b    (cmp_b),
        .i_b_ok (cmp_b_ok),
        .i_c    (r_rd1),
        .i_c_ok (cmp_c_ok),
        .o_res  (cmp_res)
    );

    // hole-based sifting: one memory write per level
    always_comb begin
        we    = 1'b0;
        waddr = r_pos;
        wdata = r_val;
        case (r_state)
            S_UP_CMP: begin
                we    = 1'b1;
                wdata = (cmp_res.pick == PICK_B) ? r_rd0 : r_val;
            end
            S_UP_FIN: begin
                we = 1'b1;
            end
            S_DN_CMP: begin
                we    = 1'b1;
                wdata = cmp_res.max_val;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    // heap memory, at most one write and two registered reads per cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd0 <= r_mem[raddr0];
        r_rd1 <= r_mem[raddr1];
    end

    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_m_tready);

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result replaces the one taken in the same cycle
            if (r_out_valid && i_m_tready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        if (cmd == CMD_INSERT) begin
                            r_removed <= '0;
                            r_rvalid  <= 1'b0;
                            r_unf     <= 1'b0;
                            if (r_count >= CW'(CAPACITY)) begin
                                r_ovf   <= 1'b1;
                                r_state <= S_DONE;
                            end else begin
                                r_ovf   <= 1'b0;
                                r_val   <= i_s_tdata;
                                r_pos   <= r_count[AW-1:0];
                                r_count <= r_count + CW'(1);
                                r_state <= (r_count == '0) ? S_UP_FIN : S_UP_RD;
                            end
                        end else begin
                            r_ovf <= 1'b0;
                            if (r_count == '0) begin
                                r_removed <= '0;
                                r_rvalid  <= 1'b0;
                                r_unf     <= 1'b1;
                                r_state   <= S_DONE;
                            end else begin
                                r_removed <= r_top;
                                r_rvalid  <= 1'b1;
                                r_unf     <= 1'b0;
                                r_count   <= r_count - CW'(1);
                                r_state   <= (r_count == CW'(1)) ? S_DONE : S_DEL_RD;
                            end
                        end
                    end
                end
                S_UP_RD: begin
                    r_state <= S_UP_CMP;
                end
                S_UP_CMP: begin
                    if (cmp_res.pick == PICK_B) begin
                        r_pos   <= parent;
                        r_state <= (parent == '0) ? S_UP_FIN : S_UP_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_UP_FIN: begin
                    // hole has reached the root
                    r_top   <= r_val;
                    r_state <= S_DONE;
                end
                S_DEL_RD: begin
                    r_state <= S_DEL_LD;
                end
                S_DEL_LD: begin
                    // last entry becomes the value sifted down from the root
                    r_val   <= r_rd0;
                    r_pos   <= '0;
                    r_state <= S_DN_RD;
                end
                S_DN_RD: begin
                    r_state <= S_DN_CMP;
                end
                S_DN_CMP: begin
                    if (r_pos == '0) begin
                        r_top <= cmp_res.max_val;
                    end
                    case (cmp_res.pick)
                        PICK_B: begin
                            r_pos   <= idx_l[AW-1:0];
                            r_state <= S_DN_RD;
                        end
                        PICK_C: begin
                            r_pos   <= idx_r[AW-1:0];
                            r_state <= S_DN_RD;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {r_unf, r_ovf, CNT_OUT_W'(r_count),
                                        (r_count != '0) ? r_top : DATA_W'(0),
                                        r_rvalid, r_removed};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    `MHPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(CAPACITY))
    `MHPQ_ASSERT_IMPL(a_dn_pos_live, i_clk, i_rst_n, r_state == S_DN_CMP, IW'(r_pos) < count_ext)
    `MHPQ_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, !s_accept, $stable(r_count))
    `MHPQ_ASSERT_IMPL(a_flags_excl, i_clk, i_rst_n, o_m_tvalid, !(o_m_tdata[70] && o_m_tdata[71]) && !(o_m_tdata[32] && o_m_tdata[71]))

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the max-heap priority queue: random insert and delete-max beats,
// a heap predictor in a small scoreboard class, and random stalls on both streams.
// Depends on mhpq_pkg and the max_heap_priority_queue RTL.
module testbench
    import mhpq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP_DEPTH = CAP_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_OPS = 375;

    // result beat, first field in the highest bits
    typedef struct packed {
        logic                     underflow;
        logic                     overflow;
        logic [CNT_OUT_W-1:0]     entry_count;
        logic signed [DATA_W-1:0] top_value;
        logic                     removed_valid;
        logic signed [DATA_W-1:0] removed_value;
    } t_heap_result;

    // Predicts the heap and holds the results still owed by the block
    class t_heap_scoreboard;
        logic signed [DATA_W-1:0] slots [HEAP_DEPTH];
        int unsigned fill = 0;
        t_heap_result due[$];
        int mismatches = 0;
        int results = 0;
        int ops = 0;
        int overflows = 0;
        int underflows = 0;
        int removals = 0;
        int full_hits = 0;

        function void rise(int unsigned pos);
            int unsigned parent;
            logic signed [DATA_W-1:0] t;
            while (pos > 0) begin
                parent = (pos - 1) / 2;
                // strict compare: on ties the parent stays
                if (!(slots[pos] > slots[parent]))
                    break;
                t = slots[pos];
                slots[pos] = slots[parent];
                slots[parent] = t;
                pos = parent;
            end
        endfunction

        function void sink(int unsigned pos);
            int unsigned big, l, r;
            logic signed [DATA_W-1:0] t;
            while (1'b1) begin
                big = pos;
                l = 2 * pos + 1;
                r = l + 1;
                if (l < fill && slots[l] > slots[big])
                    big = l;
                if (r < fill && slots[r] > slots[big])
                    big = r;
                if (big == pos)
                    break;
                t = slots[pos];
                slots[pos] = slots[big];
                slots[big] = t;
                pos = big;
            end
        endfunction

        // accepted input beat: update the heap and queue the expected result
        function void note_op(t_cmd cmd, logic signed [DATA_W-1:0] value);
            t_heap_result r;
            r = '0;
            ops++;
            if (cmd == CMD_INSERT) begin
                if (fill >= HEAP_DEPTH) begin
                    r.overflow = 1'b1;
                    overflows++;
                end else begin
                    slots[fill] = value;
                    fill++;
                    rise(fill - 1);
                    if (fill == HEAP_DEPTH)
                        full_hits++;
                end
            end else if (fill == 0) begin
                r.underflow = 1'b1;
                underflows++;
            end else begin
                r.removed_value = slots[0];
                r.removed_valid = 1'b1;
                removals++;
                fill--;
                slots[0] = slots[fill];
                sink(0);
            end
            r.top_value = (fill > 0) ? slots[0] : '0;
            r.entry_count = fill[CNT_OUT_W-1:0];
            due.push_back(r);
        endfunction

        // accepted result beat: compare with the oldest expectation
        function void check_result(logic [OUT_TDATA_W-1:0] raw);
            t_heap_result got, exp;
            got = t_heap_result'(raw);
            results++;
            if (due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with nothing expected: %h", $realtime, raw);
                return;
            end
            exp = due.pop_front();
            if (got.removed_value !== exp.removed_value || got.removed_valid !== exp.removed_valid
                || got.top_value !== exp.top_value || got.entry_count !== exp.entry_count
                || got.overflow !== exp.overflow || got.underflow !== exp.underflow) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result #%0d mismatch", $realtime, results);
                    $display("  expected removed=%0d valid=%0b top=%0d count=%0d ovf=%0b unf=%0b",
                             exp.removed_value, exp.removed_valid, exp.top_value,
                             exp.entry_count, exp.overflow, exp.underflow);
                    $display("  actual   removed=%0d valid=%0b top=%0d count=%0d ovf=%0b unf=%0b",
                             got.removed_value, got.removed_valid, got.top_value,
                             got.entry_count, got.overflow, got.underflow);
                end
            end
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;    // [31:0] value
    logic [0:0]             i_s_tuser = '0;    // [0] command
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // [31:0] removed_value, [32] removed_valid, [64:33] top_value,
    // [69:65] entry_count, [70] overflow, [71] underflow
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    t_heap_scoreboard sb = new();
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    logic rx_hold = 1'b0;
    int  quiet_cycles = 0;

    max_heap_priority_queue #(
        .CAPACITY(HEAP_DEPTH)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    always #4 i_clk = ~i_clk;

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge i_clk) begin
        i_m_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // watch both streams at the edge: note inputs first, then check results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                sb.note_op(t_cmd'(i_s_tuser[0]), i_s_tdata);
            if (o_m_tvalid && i_m_tready)
                sb.check_result(o_m_tdata);
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // one input beat, with random idle cycles ahead of it
    task automatic send_op(t_cmd cmd, logic [DATA_W-1:0] value);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        i_s_tuser  <= cmd;
        do
            @(posedge i_clk);
        while (!o_s_tready);
    endtask

    // mostly full-range values, with extremes and a narrow band for ties
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3, 4: return $urandom_range(0, 7) - 4;
            default: return $urandom;
        endcase
    endfunction

    // random operations in runs that lean toward filling, draining or neither
    task automatic run_random(int n_ops);
        int insert_pct;
        insert_pct = 50;
        for (int i = 0; i < n_ops; i++) begin
            if (i % 32 == 0) begin
                case ($urandom_range(0, 2))
                    0: insert_pct = 85;
                    1: insert_pct = 15;
                    default: insert_pct = 50;
                endcase
            end
            if ($urandom_range(0, 99) < insert_pct)
                send_op(CMD_INSERT, pick_value());
            else
                send_op(CMD_DELETE, $urandom);
        end
    endtask

    initial begin
        logic [DATA_W-1:0] fill_vals [HEAP_DEPTH];
        fill_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'd5, 32'd5,
                      32'd5, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFE, 32'd100,
                      32'hAAAA_AAAA, 32'h5555_5555, 32'd5, 32'hFFFF_FFFF};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: delete on empty, fill with extremes and ties, insert on full, drain some
        send_op(CMD_DELETE, 32'h7FFF_FFFF);
        foreach (fill_vals[k])
            send_op(CMD_INSERT, fill_vals[k]);
        send_op(CMD_INSERT, 32'd12345);
        repeat (5)
            send_op(CMD_DELETE, $urandom);

        // random phases with different idle patterns on both sides
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
                1: begin tx_idle_pct = 47; rx_stall_pct <= 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct <= 47; end
                default: begin tx_idle_pct = 30; rx_stall_pct <= 30; end
            endcase
            // back-pressure: receiver holds off while beats keep coming
            if (ph == 0) begin
                fork
                    begin
                        rx_hold <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge i_clk);
                        rx_hold <= 1'b0;
                    end
                join_none
            end
            run_random(PHASE_OPS);
        end
        i_s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Ran %0d operations, checked %0d results, %0d mismatches",
                 sb.ops, sb.results, sb.mismatches);
        $display("Covered %0d removals, %0d overflows, %0d underflows, heap full %0d times",
                 sb.removals, sb.overflows, sb.underflows, sb.full_hits);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
